FILE: design/lirs_pkg.sv
package lirs_pkg;

  // Phase accumulator format.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int PHASE_W         = PHASE_FRAC_BITS + 5;
  localparam int STEP_W          = 21;
  localparam int SUM_W           = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;
  localparam logic [PHASE_W-1:0] PHASE_MAX = '1;
  localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(79183);

  // Run length cap per native sample.
  localparam int MAX_RUN = 8;
  localparam int RUN_W   = $clog2(MAX_RUN + 1);

  // Native sample queue between front and back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // Native sample width: FM plus PSG needs one bit of headroom.
  localparam int NAT_W = 17;

  typedef struct packed {
    logic                    push;
    logic signed [NAT_W-1:0] sample;
  } q_push_t;

  typedef struct packed {
    logic                    empty;
    logic signed [NAT_W-1:0] sample;
  } q_head_t;

endpackage

FILE: design/lirs_front.sv
module lirs_front
  import lirs_pkg::*;
(
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] fm_sample,
  input  logic               fm_valid,
  input  logic signed [15:0] psg_sample,
  input  logic               psg_valid,
  input  logic               q_full,
  output q_push_t            q_push
);

  logic signed [NAT_W-1:0] fm_ext;
  logic signed [NAT_W-1:0] psg_ext;

  // Classify the beat: FM plus PSG, FM alone, or silence.
  // A beat is taken whenever the queue has room.
  always_comb begin
    fm_ext  = NAT_W'(fm_sample);
    psg_ext = psg_valid ? NAT_W'(psg_sample) : '0;
    q_push.sample = fm_valid ? (fm_ext + psg_ext) : '0;
    q_push.push   = in_valid && !q_full;
  end

  assign in_ready = !q_full;

endmodule

FILE: design/lirs_queue.sv
module lirs_queue
  import lirs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  q_push_t q_push,
  input  logic    pop,
  output logic    full,
  output q_head_t head
);

  logic signed [NAT_W-1:0] mem [QDEPTH];
  logic [QPTR_W-1:0]       wr_ptr;
  logic [QPTR_W-1:0]       rd_ptr;
  logic [QPTR_W:0]         count;
  logic                    do_pop;

  assign full        = (count == (QPTR_W+1)'(QDEPTH));
  assign head.empty  = (count == '0);
  assign head.sample = mem[rd_ptr];
  assign do_pop      = pop && !head.empty;

  // Storage for queued native samples.
  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem[wr_ptr] <= q_push.sample;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_push.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/lirs_back.sv
module lirs_back
  import lirs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [STEP_W-1:0]  phase_step,
  input  q_head_t            head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               last_of_run
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_t;

  localparam int DIFF_W = NAT_W + 1;
  localparam int PROD_W = DIFF_W + 9;
  localparam int V_W    = NAT_W + 3;

  state_t                  state;
  logic [PHASE_W-1:0]      phase;
  logic signed [NAT_W-1:0] older;
  logic signed [NAT_W-1:0] newer;
  logic [RUN_W-1:0]        run_cnt;
  logic signed [PROD_W-1:0] prod;

  logic                     slot_free;
  logic                     emit_fire;
  logic [SUM_W-1:0]         phase_sum;
  logic [PHASE_W-1:0]       phase_adv;
  logic [RUN_W-1:0]         run_cnt_next;
  logic                     last;
  logic signed [DIFF_W-1:0] diff;
  logic signed [8:0]        frac;
  logic signed [PROD_W-1:0] quot;
  logic signed [V_W-1:0]    v;
  logic signed [15:0]       v_sat;
  logic                     run_more;

  assign pop       = (state == S_IDLE) && !head.empty;
  assign slot_free = !out_valid || out_ready;
  assign emit_fire = (state == S_EMIT) && slot_free;

  // Interpolation weight is the top 8 fraction bits of the phase.
  always_comb begin
    diff = DIFF_W'(newer) - DIFF_W'(older);
    frac = {1'b0, phase[PHASE_FRAC_BITS-1 -: 8]};
    run_more = (run_cnt < RUN_W'(MAX_RUN)) && (phase < PHASE_ONE);
  end

  // Phase advance with saturation, and the end-of-run decision.
  always_comb begin
    phase_sum    = SUM_W'(phase) + SUM_W'(phase_step);
    phase_adv    = (phase_sum > SUM_W'(PHASE_MAX)) ? PHASE_MAX : phase_sum[PHASE_W-1:0];
    run_cnt_next = run_cnt + 1'b1;
    last         = (run_cnt_next == RUN_W'(MAX_RUN)) || (phase_adv >= PHASE_ONE);
  end

  // Floor divide by 256 and add to the older sample, then clamp.
  always_comb begin
    quot = prod >>> 8;
    v    = V_W'(older) + quot[V_W-1:0];
    if (v > V_W'(32767)) begin
      v_sat = 16'sh7fff;
    end else if (v < -V_W'(32768)) begin
      v_sat = -16'sh8000;
    end else begin
      v_sat = v[15:0];
    end
  end

  // Sequencer: load a native sample, then compute and emit each output.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PHASE_ONE;
      older     <= '0;
      newer     <= '0;
      run_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      // The output beat stays offered until taken; a new one can replace it as it is taken.
      out_valid <= emit_fire || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          if (!head.empty) begin
            older   <= newer;
            newer   <= head.sample;
            phase   <= (phase >= PHASE_ONE) ? (phase - PHASE_ONE) : '0;
            run_cnt <= '0;
            state   <= S_RUN;
          end
        end
        S_RUN: begin
          if (run_more) begin
            prod  <= PROD_W'(diff) * PROD_W'(frac);
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            sample_out  <= v_sat;
            last_of_run <= last;
            phase       <= phase_adv;
            run_cnt     <= run_cnt_next;
            state       <= last ? S_IDLE : S_RUN;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: design/linear_interpolating_resampler_top.sv
// Channel  Handshake            Payload
// in       in_valid / in_ready  fm_sample, fm_valid, psg_sample, psg_valid
// out      out_valid/out_ready  sample_out, last_of_run
// cfg      cfg_we               cfg_wdata (phase_step)
//
// In the back end each native sample goes through one load state, then a
// multiply state and an emit state per output (the load and multiply states
// only, when it yields none). A four-entry queue decouples the input side.
// Reset is synchronous and returns phase, sample pair and step to defaults.
// A stalled output holds the back end in its emit state; input keeps
// flowing until the queue fills.
module linear_interpolating_resampler_top
  import lirs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] fm_sample,
  input  logic               fm_valid,
  input  logic signed [15:0] psg_sample,
  input  logic               psg_valid,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] sample_out,
  output logic               last_of_run,
  input  logic               cfg_we,
  input  logic [STEP_W-1:0]  cfg_wdata
);

  logic [STEP_W-1:0] phase_step;
  q_push_t           q_push;
  q_head_t           head;
  logic              q_full;
  logic              pop;

  // Step register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= STEP_RESET;
    end else if (cfg_we) begin
      phase_step <= cfg_wdata;
    end
  end

  lirs_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fm_sample  (fm_sample),
    .fm_valid   (fm_valid),
    .psg_sample (psg_sample),
    .psg_valid  (psg_valid),
    .q_full     (q_full),
    .q_push     (q_push)
  );

  lirs_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_push (q_push),
    .pop    (pop),
    .full   (q_full),
    .head   (head)
  );

  lirs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_step  (phase_step),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sample_out  (sample_out),
    .last_of_run (last_of_run)
  );

endmodule

FILE: design/lirs_checker.sv
module lirs_checker
  import lirs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] sample_out,
  input logic               last_of_run
);

  // A stalled output beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(sample_out) && $stable(last_of_run))
    else $error("output payload changed while stalled");

  // Reset leaves no output pending.
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Reset empties the queue, so input is ready right after it.
  a_rst_in: assert property (@(posedge clk) rst |=> in_ready)
    else $error("input not ready after reset");

endmodule

bind linear_interpolating_resampler_top lirs_checker u_lirs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .sample_out  (sample_out),
  .last_of_run (last_of_run)
);

FILE: verif/linear_interpolating_resampler_checker.sv
module linear_interpolating_resampler_checker
  import lirs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [15:0] fm_sample,
  input  logic               fm_valid,
  input  logic signed [15:0] psg_sample,
  input  logic               psg_valid,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [15:0] sample_out,
  input  logic               last_of_run,
  input  logic               cfg_we,
  input  logic [STEP_W-1:0]  cfg_wdata,
  output int                 mismatches,
  output int                 pending,
  output int                 beats_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               last;
  } out_beat_t;

  // Output beats predicted but not yet seen on the output channel.
  out_beat_t expected_beats[$];

  // Shadow copy of the resampler state.
  logic [STEP_W-1:0]       step_now;
  logic [PHASE_W-1:0]      phase_now;
  logic signed [NAT_W-1:0] older_nat;
  logic signed [NAT_W-1:0] newer_nat;
  int                      err_total;
  int                      beat_total;

  // Blend the sample pair with the top 8 fraction bits of the phase, then clamp.
  function automatic logic signed [15:0] blend_pair(input logic [PHASE_W-1:0] acc,
                                                     input logic signed [NAT_W-1:0] a,
                                                     input logic signed [NAT_W-1:0] b);
    int frac;
    int diff;
    int v;
    frac = int'(acc[PHASE_FRAC_BITS-1 -: 8]);
    diff = int'(b) - int'(a);
    v = int'(a) + ((diff * frac) >>> 8);
    if (v > 32767) begin
      v = 32767;
    end else if (v < -32768) begin
      v = -32768;
    end
    return v[15:0];
  endfunction

  // Push one native sample into the pair and queue every output it yields.
  task automatic resample_native(input logic signed [15:0] fm, input logic fv,
                                 input logic signed [15:0] psg, input logic pv);
    logic signed [NAT_W-1:0] nat;
    logic [SUM_W-1:0]        sum;
    out_beat_t               beat;
    int                      run;
    nat = '0;
    if (fv) begin
      nat = NAT_W'(fm);
      if (pv) begin
        nat = nat + NAT_W'(psg);
      end
    end
    older_nat = newer_nat;
    newer_nat = nat;

    // A phase that never reached a whole sample restarts at zero.
    if (phase_now >= PHASE_ONE) begin
      phase_now = phase_now - PHASE_ONE;
    end else begin
      phase_now = '0;
    end

    run = 0;
    while (run < MAX_RUN && phase_now < PHASE_ONE) begin
      beat.sample = blend_pair(phase_now, older_nat, newer_nat);
      sum = SUM_W'(phase_now) + SUM_W'(step_now);
      phase_now = (sum > SUM_W'(PHASE_MAX)) ? PHASE_MAX : sum[PHASE_W-1:0];
      run++;
      beat.last = (run == MAX_RUN) || (phase_now >= PHASE_ONE);
      expected_beats.push_back(beat);
    end
  endtask

  task automatic report_mismatch(input string what);
    err_total++;
    if (err_total <= MAX_REPORTS) begin
      $display("%t: %s", $realtime, what);
    end
  endtask

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (rst) begin
      step_now = STEP_RESET;
      phase_now = PHASE_ONE;
      older_nat = '0;
      newer_nat = '0;
      err_total = 0;
      beat_total = 0;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        step_now = cfg_wdata;
      end
      if (in_valid && in_ready) begin
        resample_native(fm_sample, fm_valid, psg_sample, psg_valid);
      end
      if (out_valid && out_ready) begin
        beat_total++;
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected output beat: sample_out %0d last_of_run %0b",
                                    sample_out, last_of_run));
        end else begin
          want = expected_beats.pop_front();
          if (sample_out !== want.sample || last_of_run !== want.last) begin
            report_mismatch($sformatf(
              "beat %0d: sample_out exp %0d got %0d, last_of_run exp %0b got %0b",
              beat_total, want.sample, sample_out, want.last, last_of_run));
          end
        end
      end
    end
    mismatches    <= err_total;
    pending       <= expected_beats.size();
    beats_checked <= beat_total;
  end

endmodule

FILE: verif/linear_interpolating_resampler_top_tb.sv
module linear_interpolating_resampler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lirs_pkg::*;

  localparam int DRAIN_CYCLES   = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STEP_PLANS     = 10;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] fm_sample = '0;
  logic               fm_valid = 1'b0;
  logic signed [15:0] psg_sample = '0;
  logic               psg_valid = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] sample_out;
  logic               last_of_run;
  logic               cfg_we = 1'b0;
  logic [STEP_W-1:0]  cfg_wdata = '0;

  int mismatches;
  int pending;
  int beats_checked;
  int native_count = 0;
  int settings_count = 0;
  int idle_cycles = 0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;

  linear_interpolating_resampler_top DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fm_sample  (fm_sample),
    .fm_valid   (fm_valid),
    .psg_sample (psg_sample),
    .psg_valid  (psg_valid),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out),
    .last_of_run(last_of_run),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  linear_interpolating_resampler_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .fm_sample    (fm_sample),
    .fm_valid     (fm_valid),
    .psg_sample   (psg_sample),
    .psg_valid    (psg_valid),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sample_out   (sample_out),
    .last_of_run  (last_of_run),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .mismatches   (mismatches),
    .pending      (pending),
    .beats_checked(beats_checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Offer one native sample and hold it until the input beat is taken.
  task automatic send_native(input logic signed [15:0] fm, input logic fv,
                             input logic signed [15:0] psg, input logic pv);
    int gap;
    if ($urandom_range(0, 15) == 0) begin
      in_burst = !in_burst;
    end
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    fm_sample  <= fm;
    fm_valid   <= fv;
    psg_sample <= psg;
    psg_valid  <= pv;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    native_count++;
  endtask

  // Wait for the block to go quiet, then write a new phase step.
  task automatic program_step(input logic [STEP_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // Mostly random samples, with the rails showing up now and then.
  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Output side: random stalls per beat, with stretches of none.
  initial begin
    int stall;
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) begin
        out_burst = !out_burst;
      end
      stall = out_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Count cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [STEP_W-1:0] step_val;
    int                items;
    logic              fv;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset step: warmup zeros, flag combinations,
    // both rails summed past 16 bits, and full-scale swings.
    send_native(16'sh7FFF, 1'b0, 16'sh8000, 1'b1);
    send_native(16'sh8000, 1'b0, 16'sh7FFF, 1'b0);
    send_native(16'sh5A5A, 1'b0, 16'shA5A5, 1'b0);
    send_native(16'sh7FFF, 1'b1, 16'sh0000, 1'b0);
    send_native(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    send_native(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    send_native(16'sh8000, 1'b1, 16'sh8000, 1'b1);
    send_native(16'sh8000, 1'b1, 16'sh8000, 1'b1);
    send_native(16'sh8000, 1'b1, 16'sh7FFF, 1'b0);
    send_native(16'sh7FFF, 1'b1, 16'sh8000, 1'b1);
    send_native(16'sh0000, 1'b1, 16'shFFFF, 1'b1);
    send_native(16'shFFFF, 1'b1, 16'sh0001, 1'b1);
    send_native(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    send_native(16'sh8000, 1'b1, 16'sh8000, 1'b1);
    send_native(16'sh7FFF, 1'b1, 16'sh7FFF, 1'b1);
    send_native(16'sh0000, 1'b0, 16'sh0000, 1'b0);

    // Random part over a series of phase steps. Steps under 8192 let the
    // run cap cut a run short; the all-ones step drives the phase into
    // saturation; the largest steps leave most samples with no output.
    for (int p = 0; p < STEP_PLANS; p++) begin
      case (p)
        0:       step_val = 21'd8192;
        1:       step_val = 21'd4096;
        2:       step_val = 21'd1000;
        3:       step_val = 21'd65536;
        4:       step_val = 21'd1048576;
        5:       step_val = '1;
        7:       step_val = 21'd32768;
        9:       step_val = STEP_RESET;
        default: step_val = STEP_W'($urandom_range(8192, 1048576));
      endcase
      program_step(step_val);
      items = (step_val >= 21'd1048576) ? 36 : 20;
      for (int i = 0; i < items; i++) begin
        fv = ($urandom_range(0, 9) != 0);
        send_native(pick_sample(), fv, pick_sample(), 1'($urandom_range(0, 1)));
      end
    end

    // Drain what is still in flight, then give the verdict.
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("summary: %0d native samples over %0d step settings, %0d output beats checked",
             native_count, settings_count, beats_checked);
    if (mismatches == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d beats still expected", mismatches, pending);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
